/* design/thacc_pkg.sv */
// ----------------------------------------------------------------------------
// thacc_pkg
// Shared widths, defaults, register indexes and controller states of the
// trilinear histogram accumulator.
// ----------------------------------------------------------------------------
package thacc_pkg;

  localparam int MAX_WIDTH_DEF = 4;
  localparam int MAX_BINS_DEF  = 8;
  localparam int FRAC_BITS_DEF = 8;

  localparam int POS_W     = 16;
  localparam int MAG_W     = 16;
  localparam int MAG_FRAC  = 8;
  localparam int OUT_FRAC  = 16;
  localparam int SUM_W     = 40;
  localparam int SEL_W     = 7;
  localparam int GW_W      = 3;
  localparam int OB_W      = 4;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 4;

  localparam logic [GW_W-1:0] GW_RESET = 3'd4;
  localparam logic [OB_W-1:0] OB_RESET = 4'd8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_WIDTH  = 1'b0,
    CFG_ORIENT_BINS = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_READ_WB,
    ST_ACC_DIV,
    ST_ACC_RUN,
    ST_ACC_DRAIN
  } state_t;

endpackage

/* design/trilinear_histogram_accumulate.sv */
// ----------------------------------------------------------------------------
// trilinear_histogram_accumulate
// Trilinear accumulation of gradient samples into a row x column x
// orientation histogram, with read-and-clear of single bins.
//
// Channels: input items (kind, row_pos, col_pos, orient_pos, magnitude,
// bin_select) on in_valid/in_ready, results (bin_value, bin_echo) on
// out_valid/out_ready, register writes on cfg_valid/cfg_ready (cfg_index
// 0 grid_width, 1 orient_bins), always ready.
// An accumulate item gives no result; it first passes through the
// bit-serial orientation modulo, then steps through the eight neighbour
// bins in the dual-port bin store and drains the last write-back; no
// further item is accepted until the controller is back in ST_IDLE.
// A read item waits in ST_READ for a free output register; ST_READ_WB
// clears the bin and registers the result, then the next item is taken.
// Reset: the bin store is cleared by a sweep over all MAX_WIDTH^2 * MAX_BINS
// addresses (128 by default), during which no item is accepted.
// A stalled receiver holds the result in the output register; further
// accumulate items proceed, a further read waits until the register frees.
// ----------------------------------------------------------------------------
module trilinear_histogram_accumulate #(
  parameter int MAX_WIDTH = thacc_pkg::MAX_WIDTH_DEF,
  parameter int MAX_BINS  = thacc_pkg::MAX_BINS_DEF,
  parameter int FRAC_BITS = thacc_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 kind,
  input  logic signed [thacc_pkg::POS_W-1:0]   row_pos,
  input  logic signed [thacc_pkg::POS_W-1:0]   col_pos,
  input  logic signed [thacc_pkg::POS_W-1:0]   orient_pos,
  input  logic [thacc_pkg::MAG_W-1:0]          magnitude,
  input  logic [thacc_pkg::SEL_W-1:0]          bin_select,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [thacc_pkg::SUM_W-1:0]          bin_value,
  output logic [thacc_pkg::SEL_W-1:0]          bin_echo,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [thacc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [thacc_pkg::CFG_DAT_W-1:0]      cfg_data
);

  localparam int POS_W   = thacc_pkg::POS_W;
  localparam int MAG_W   = thacc_pkg::MAG_W;
  localparam int SUM_W   = thacc_pkg::SUM_W;
  localparam int SEL_W   = thacc_pkg::SEL_W;
  localparam int DEPTH   = MAX_WIDTH * MAX_WIDTH * MAX_BINS;
  localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int WW      = $clog2(MAX_WIDTH + 1);
  localparam int BW      = $clog2(MAX_BINS + 1);
  localparam int OW      = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int FLW     = POS_W - FRAC_BITS;
  localparam int WTW     = FRAC_BITS + 1;
  localparam int RCW     = 2 * WTW;
  localparam int OMW     = WTW + MAG_W;
  localparam int PW      = RCW + OMW;
  localparam int SH      = 3 * FRAC_BITS + thacc_pkg::MAG_FRAC - thacc_pkg::OUT_FRAC;
  localparam int ADDW    = PW - SH;
  localparam int ONE_INT = 1 << FRAC_BITS;

  thacc_pkg::state_t state, state_next;

  // configuration
  logic [thacc_pkg::GW_W-1:0] grid_width;
  logic [thacc_pkg::OB_W-1:0] orient_bins;
  logic [WW-1:0]              eff_w;
  logic [BW-1:0]              eff_b;
  logic                       acc_ok;

  // item
  logic signed [FLW-1:0]      rf;
  logic signed [FLW-1:0]      cf;
  logic [FRAC_BITS-1:0]       rfr;
  logic [FRAC_BITS-1:0]       cfr;
  logic [FRAC_BITS-1:0]       ofr;
  logic [MAG_W-1:0]           mag;
  logic [SEL_W-1:0]           sel;
  logic                       sel_ok;
  logic [AW-1:0]              sel_addr;

  logic [WTW-1:0]             wr_w [2];
  logic [WTW-1:0]             wc_w [2];
  logic [WTW-1:0]             wo_w [2];
  logic [RCW-1:0]             rc [4];
  logic [OMW-1:0]             om [2];

  logic                       rem_start;
  logic                       rem_done;
  logic [OW-1:0]              rem_lo;
  logic [OW-1:0]              o_lo;
  logic [OW-1:0]              o_hi;
  logic [BW-1:0]              o_inc;

  // corner sweep
  logic [2:0]                 corner;
  logic [FLW:0]               r_s;
  logic [FLW:0]               c_s;
  logic                       r_ok;
  logic                       c_ok;
  logic [OW-1:0]              o_sel;
  logic [AW-1:0]              idx;
  logic [PW-1:0]              prod;
  logic                       s1_go;

  logic                       s2_valid;
  logic [AW-1:0]              s2_idx;
  logic [ADDW-1:0]            s2_add;
  logic                       s2_fwd;
  logic [SUM_W-1:0]           s2_fwd_data;
  logic [SUM_W-1:0]           base;
  logic [SUM_W:0]             sum;
  logic [SUM_W-1:0]           sum_sat;

  logic [AW-1:0]              clr_addr;
  logic                       out_free;

  logic                       ram_we;
  logic [AW-1:0]              ram_waddr;
  logic [SUM_W-1:0]           ram_wdata;
  logic                       ram_re;
  logic [AW-1:0]              ram_raddr;
  logic [SUM_W-1:0]           ram_rdata;

  assign cfg_ready = 1'b1;

  assign eff_w  = (32'(grid_width) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(grid_width);
  assign eff_b  = (32'(orient_bins) > MAX_BINS) ? BW'(MAX_BINS) : BW'(orient_bins);
  assign acc_ok = (eff_w != '0) && (eff_b != '0);

  assign sel_ok   = 32'(sel) < DEPTH;
  assign sel_addr = AW'(sel);
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= thacc_pkg::GW_RESET;
      orient_bins <= thacc_pkg::OB_RESET;
    end else if (cfg_valid) begin
      case (thacc_pkg::cfg_idx_t'(cfg_index))
        thacc_pkg::CFG_GRID_WIDTH:  grid_width  <= cfg_data[thacc_pkg::GW_W-1:0];
        thacc_pkg::CFG_ORIENT_BINS: orient_bins <= cfg_data[thacc_pkg::OB_W-1:0];
        default: ;
      endcase
    end
  end

  // item capture, floor is the arithmetic shift, fraction the low bits
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      rf  <= row_pos[POS_W-1:FRAC_BITS];
      cf  <= col_pos[POS_W-1:FRAC_BITS];
      rfr <= row_pos[FRAC_BITS-1:0];
      cfr <= col_pos[FRAC_BITS-1:0];
      ofr <= orient_pos[FRAC_BITS-1:0];
      mag <= magnitude;
      sel <= bin_select;
    end
  end

  assign wr_w[0] = WTW'(ONE_INT) - WTW'(rfr);
  assign wr_w[1] = WTW'(rfr);
  assign wc_w[0] = WTW'(ONE_INT) - WTW'(cfr);
  assign wc_w[1] = WTW'(cfr);
  assign wo_w[0] = WTW'(ONE_INT) - WTW'(ofr);
  assign wo_w[1] = WTW'(ofr);

  // weight products, settled long before the modulo finishes
  always_ff @(posedge clk) begin
    if (state == thacc_pkg::ST_ACC_DIV) begin
      for (int k = 0; k < 4; k++) begin
        rc[k] <= RCW'(wr_w[k / 2]) * RCW'(wc_w[k % 2]);
      end
      for (int h = 0; h < 2; h++) begin
        om[h] <= OMW'(wo_w[h]) * OMW'(mag);
      end
    end
  end

  assign rem_start = in_valid && in_ready && !kind && acc_ok;

  thacc_rem #(
    .MAX_BINS  (MAX_BINS),
    .FRAC_BITS (FRAC_BITS)
  ) u_rem (
    .clk     (clk),
    .rst     (rst),
    .start   (rem_start),
    .value   (orient_pos[POS_W-1:FRAC_BITS]),
    .modulus (eff_b),
    .done    (rem_done),
    .rem     (rem_lo)
  );

  assign o_inc = BW'(rem_lo) + BW'(1);

  always_ff @(posedge clk) begin
    if (rem_done) begin
      o_lo <= rem_lo;
      o_hi <= (o_inc == eff_b) ? '0 : OW'(o_inc);
    end
  end

  // neighbour bin address and weighted add
  assign r_s   = {rf[FLW-1], rf} + (FLW+1)'(corner[2]);
  assign c_s   = {cf[FLW-1], cf} + (FLW+1)'(corner[1]);
  assign r_ok  = !r_s[FLW] && (r_s < (FLW+1)'(eff_w));
  assign c_ok  = !c_s[FLW] && (c_s < (FLW+1)'(eff_w));
  assign o_sel = corner[0] ? o_hi : o_lo;
  assign idx   = AW'((AW'(r_s) * AW'(eff_w) + AW'(c_s)) * AW'(eff_b) + AW'(o_sel));
  assign prod  = PW'(rc[corner[2:1]]) * PW'(om[corner[0]]);
  assign s1_go = (state == thacc_pkg::ST_ACC_RUN) && r_ok && c_ok;

  assign base    = s2_fwd ? s2_fwd_data : ram_rdata;
  assign sum     = {1'b0, base} + (SUM_W+1)'(s2_add);
  assign sum_sat = sum[SUM_W] ? {SUM_W{1'b1}} : sum[SUM_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      corner   <= '0;
      clr_addr <= '0;
    end else begin
      s2_valid <= s1_go;
      if (state == thacc_pkg::ST_ACC_RUN) begin
        corner <= corner + 3'd1;
      end
      if (state == thacc_pkg::ST_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
    end
  end

  // same bin written back this cycle as read now: take the new sum
  always_ff @(posedge clk) begin
    s2_idx      <= idx;
    s2_add      <= prod[PW-1:SH];
    s2_fwd      <= s2_valid && (s2_idx == idx);
    s2_fwd_data <= sum_sat;
  end

  thacc_bin_ram #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (SUM_W)
  ) u_bin_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= thacc_pkg::ST_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == thacc_pkg::ST_READ_WB) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == thacc_pkg::ST_READ_WB) begin
      bin_value <= sel_ok ? ram_rdata : '0;
      bin_echo  <= sel;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      thacc_pkg::ST_CLEAR: begin
        if (clr_addr == AW'(DEPTH - 1)) state_next = thacc_pkg::ST_IDLE;
      end
      thacc_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (kind) state_next = thacc_pkg::ST_READ;
          else if (acc_ok) state_next = thacc_pkg::ST_ACC_DIV;
        end
      end
      thacc_pkg::ST_READ: begin
        if (out_free) state_next = thacc_pkg::ST_READ_WB;
      end
      thacc_pkg::ST_READ_WB: state_next = thacc_pkg::ST_IDLE;
      thacc_pkg::ST_ACC_DIV: begin
        if (rem_done) state_next = thacc_pkg::ST_ACC_RUN;
      end
      thacc_pkg::ST_ACC_RUN: begin
        if (corner == 3'd7) state_next = thacc_pkg::ST_ACC_DRAIN;
      end
      thacc_pkg::ST_ACC_DRAIN: state_next = thacc_pkg::ST_IDLE;
      default: state_next = thacc_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = s2_idx;
    ram_wdata = sum_sat;
    ram_re    = 1'b0;
    ram_raddr = idx;
    case (state)
      thacc_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '0;
      end
      thacc_pkg::ST_IDLE: begin
        in_ready = 1'b1;
      end
      thacc_pkg::ST_READ: begin
        ram_re    = out_free && sel_ok;
        ram_raddr = sel_addr;
      end
      thacc_pkg::ST_READ_WB: begin
        ram_we    = sel_ok;
        ram_waddr = sel_addr;
        ram_wdata = '0;
      end
      thacc_pkg::ST_ACC_RUN: begin
        ram_we = s2_valid;
        ram_re = s1_go;
      end
      thacc_pkg::ST_ACC_DRAIN: begin
        ram_we = s2_valid;
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_write_in_range : assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (32'(ram_waddr) < DEPTH))
    else $error("bin store write beyond depth");

  a_wb_in_sweep : assert property (@(posedge clk) disable iff (rst)
    s2_valid |-> (state == thacc_pkg::ST_ACC_RUN || state == thacc_pkg::ST_ACC_DRAIN))
    else $error("bin write-back outside the corner sweep");

  a_result_from_read : assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == thacc_pkg::ST_READ_WB))
    else $error("result without a read item");

  a_fwd_needs_wb : assert property (@(posedge clk) disable iff (rst)
    (s2_valid && s2_fwd) |-> $past(s2_valid && s1_go))
    else $error("forwarding without an overlapping write-back");
`endif

endmodule

/* design/thacc_bin_ram.sv */
// ----------------------------------------------------------------------------
// thacc_bin_ram
// Histogram bin store: one write port and one read port, registered read.
// ----------------------------------------------------------------------------
module thacc_bin_ram #(
  parameter int DEPTH = 128,
  parameter int AW    = 7,
  parameter int DW    = 40
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/thacc_rem.sv */
// ----------------------------------------------------------------------------
// thacc_rem
// Bit-serial true modulo of the signed orientation floor by the bin count,
// one quotient bit per cycle; negative values wrap into 0..b-1.
// ----------------------------------------------------------------------------
module thacc_rem #(
  parameter int MAX_BINS  = thacc_pkg::MAX_BINS_DEF,
  parameter int FRAC_BITS = thacc_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic signed [thacc_pkg::POS_W-FRAC_BITS-1:0] value,
  input  logic [$clog2(MAX_BINS+1)-1:0]        modulus,
  output logic                                 done,
  output logic [((MAX_BINS > 1) ? $clog2(MAX_BINS) : 1)-1:0] rem
);

  localparam int FLW = thacc_pkg::POS_W - FRAC_BITS;
  localparam int OW  = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int RW  = $clog2(MAX_BINS) + 2;
  localparam int CNW = $clog2(FLW + 1);

  logic           run;
  logic [CNW-1:0] cnt;
  logic [FLW-1:0] mag;
  logic           neg;
  logic [RW-1:0]  r;
  logic [RW-1:0]  r_shift;
  logic [RW-1:0]  r_next;
  logic [RW-1:0]  mod_ext;
  logic [RW-1:0]  r_wrap;

  assign mod_ext = RW'(modulus);
  assign r_shift = {r[RW-2:0], mag[FLW-1]};
  assign r_next  = (r_shift >= mod_ext) ? (r_shift - mod_ext) : r_shift;
  assign r_wrap  = (neg && (r != '0)) ? (mod_ext - r) : r;
  assign rem     = OW'(r_wrap);

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= run && (cnt == CNW'(1));
      if (start) begin
        run <= 1'b1;
        cnt <= CNW'(FLW);
      end else if (run) begin
        cnt <= cnt - CNW'(1);
        if (cnt == CNW'(1)) begin
          run <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= value[FLW-1];
      mag <= value[FLW-1] ? FLW'(-value) : FLW'(value);
      r   <= '0;
    end else if (run) begin
      mag <= {mag[FLW-2:0], 1'b0};
      r   <= r_next;
    end
  end

`ifndef SYNTHESIS
  a_rem_range : assert property (@(posedge clk) disable iff (rst)
    done |-> (r < mod_ext))
    else $error("remainder not below modulus");

  a_done_after_run : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(run))
    else $error("done without a running division");

  a_no_restart : assert property (@(posedge clk) disable iff (rst)
    run |-> !start)
    else $error("division restarted while running");
`endif

endmodule
